@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the particle pool.
// Each macro expands to one labelled concurrent assertion reporting by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define PP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define PP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pp_pkg.sv @@
// Package for the particle pool: sizes, word layouts, command codes and state type.
// Used by particle_pool_next_fit and its checker; depends on nothing.
`timescale 1ns / 1ps

package pp_pkg;

    localparam int PP_POOL_SLOTS   = 64;
    localparam int PP_SLOT_W       = 6;
    localparam int PP_LIFE_W       = 17;
    localparam int PP_DEC_W        = 24;
    localparam int PP_COORD_W      = 16;
    localparam int PP_COLOR_W      = 32;
    localparam int PP_DATA_W       = 3 * PP_COORD_W + PP_COLOR_W;
    localparam int PP_S_TDATA_W    = 96;
    localparam int PP_S_TUSER_W    = 2;
    localparam int PP_M_TDATA_W    = 88;
    localparam int PP_M_PAD_W      = PP_M_TDATA_W - PP_DATA_W - PP_SLOT_W;
    localparam int PP_CFG_W        = 16;

    localparam logic [PP_LIFE_W-1:0] PP_FULL_LIFE     = 17'h10000;
    localparam logic [PP_CFG_W-1:0]  PP_DECAY_RESET   = 16'd256;

    typedef enum logic [PP_S_TUSER_W-1:0] {
        CMD_ADD  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_DRAW = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_DRAW,
        ST_ACK
    } state_t;

endpackage

@@ rtl/particle_pool_next_fit.sv @@
// Particle pool: one command at a time, walking the slots one per cycle through
// the life memory (tick) or the payload memory (draw) or the active bits (add),
// except that a draw holds its scan while a result word waits. Every command may
// also wait on the result side; a new word is taken once the command ends. Reset
// clears control state and the active bits, so every slot is free at once; there
// is no clearing pass and decay_rate returns to 1.0 (256).
`timescale 1ns / 1ps

module particle_pool_next_fit
    import pp_pkg::*;
#(
    parameter int POOL_SLOTS = PP_POOL_SLOTS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // pos_x[15:0], pos_y[31:16], size_in[47:32], color_in[79:48], delta_time[95:80]
    input  logic [PP_S_TDATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [PP_S_TUSER_W-1:0] s_tuser,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // slot[5:0], out_x[21:6], out_y[37:22], out_size[53:38], out_color[85:54], zero[87:86]
    output logic [PP_M_TDATA_W-1:0] m_tdata,
    // valid_res[0]
    output logic                    m_tuser,
    output logic                    m_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic                    cfg_we,
    input  logic [PP_CFG_W-1:0]     cfg_wdata
);

    localparam int IDX_W = $clog2(POOL_SLOTS);
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);

    state_t state_reg, state_next;

    logic [PP_CFG_W-1:0]   decay_rate_reg;
    logic [PP_DATA_W-1:0]  item_reg, item_next;
    logic [PP_DEC_W-1:0]   dec_reg, dec_next;
    logic [31:0]           dec_prod;

    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next, idx_inc;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]      p_idx_reg, p_idx_next;
    logic [CNT_W-1:0]      emit_cnt_reg, emit_cnt_next;
    logic [CNT_W-1:0]      act_cnt_reg, act_cnt_next;
    logic [POOL_SLOTS-1:0] active_reg, active_next;
    logic [IDX_W-1:0]      search_start_reg, search_start_next;

    logic [PP_LIFE_W-1:0]  life_mem [POOL_SLOTS];
    logic [PP_DATA_W-1:0]  data_mem [POOL_SLOTS];
    logic [PP_LIFE_W-1:0]  life_rd_reg;
    logic [PP_DATA_W-1:0]  data_rd_reg;
    logic                  life_we, life_re, data_we, data_re;
    logic [IDX_W-1:0]      life_wa, data_wa;
    logic [PP_LIFE_W-1:0]  life_wd, life_new;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [PP_M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;
    logic                  m_tlast_reg, m_tlast_next;
    logic                  out_load;

    logic                  in_acc, out_ok, cur_active, emit_last;
    cmd_t                  in_cmd;
    logic [IDX_W-1:0]      add_slot;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign in_cmd     = cmd_t'(s_tuser);
    assign out_ok     = !m_tvalid_reg || m_tready;
    assign cur_active = active_reg[scan_idx_reg];
    assign idx_inc    = (scan_idx_reg == IDX_W'(POOL_SLOTS - 1)) ? '0 : scan_idx_reg + 1'b1;
    assign emit_last  = (emit_cnt_reg == (act_cnt_reg - CNT_W'(1)));
    assign add_slot   = cur_active ? '0 : scan_idx_reg;
    assign dec_prod   = decay_rate_reg * s_tdata[95:80];
    // Saturating decrement: the Q8.16 decrement is compared in full width.
    assign life_new   = (dec_reg >= PP_DEC_W'(life_rd_reg)) ? '0
                        : life_rd_reg - dec_reg[PP_LIFE_W-1:0];

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        CMD_ADD:  state_next = ST_ADD;
                        CMD_TICK: state_next = ST_TICK;
                        CMD_DRAW: state_next = (act_cnt_reg == '0) ? ST_ACK : ST_DRAW;
                        CMD_NOP:  state_next = ST_ACK;
                        default:  state_next = ST_ACK;
                    endcase
                end
            end
            ST_ADD: begin
                if ((!cur_active || scan_cnt_reg == CNT_W'(1)) && out_ok) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (scan_cnt_reg == '0 && !p_vld_reg) begin
                    state_next = ST_ACK;
                end
            end
            ST_DRAW: begin
                if (p_vld_reg && out_ok && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACK: begin
                if (out_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control, memory ports and the result register.
    always_comb begin
        item_next         = item_reg;
        dec_next          = dec_reg;
        scan_idx_next     = scan_idx_reg;
        scan_cnt_next     = scan_cnt_reg;
        p_vld_next        = p_vld_reg;
        p_idx_next        = p_idx_reg;
        emit_cnt_next     = emit_cnt_reg;
        act_cnt_next      = act_cnt_reg;
        active_next       = active_reg;
        search_start_next = search_start_reg;
        life_we           = 1'b0;
        life_re           = 1'b0;
        life_wa           = p_idx_reg;
        life_wd           = life_new;
        data_we           = 1'b0;
        data_re           = 1'b0;
        data_wa           = add_slot;
        out_load          = 1'b0;
        m_tdata_next      = '0;
        m_tuser_next      = 1'b0;
        m_tlast_next      = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    item_next     = s_tdata[PP_DATA_W-1:0];
                    dec_next      = dec_prod[31:8];
                    // The pointer only ever holds a scanned slot, so it lies in the pool.
                    scan_idx_next = (in_cmd == CMD_ADD) ? search_start_reg : '0;
                    scan_cnt_next = CNT_W'(POOL_SLOTS);
                    p_vld_next    = 1'b0;
                    emit_cnt_next = '0;
                end
            end
            ST_ADD: begin
                if (!cur_active || scan_cnt_reg == CNT_W'(1)) begin
                    if (out_ok) begin
                        life_we      = 1'b1;
                        life_wa      = add_slot;
                        life_wd      = PP_FULL_LIFE;
                        data_we      = 1'b1;
                        out_load     = 1'b1;
                        m_tuser_next = 1'b1;
                        m_tdata_next = {PP_M_PAD_W'(0), item_reg, PP_SLOT_W'(add_slot)};
                        // With the pool full slot 0 is overwritten and stays active.
                        if (!cur_active) begin
                            active_next[scan_idx_reg] = 1'b1;
                            act_cnt_next      = act_cnt_reg + 1'b1;
                            search_start_next = scan_idx_reg;
                        end
                    end
                end else begin
                    scan_idx_next = idx_inc;
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end
            end
            ST_TICK: begin
                if (scan_cnt_reg != '0) begin
                    life_re       = cur_active;
                    p_vld_next    = cur_active;
                    p_idx_next    = scan_idx_reg;
                    scan_idx_next = idx_inc;
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end else begin
                    p_vld_next = 1'b0;
                end
                if (p_vld_reg) begin
                    life_we = 1'b1;
                    if (life_new == '0) begin
                        active_next[p_idx_reg] = 1'b0;
                        act_cnt_next = act_cnt_next - 1'b1;
                    end
                end
            end
            ST_DRAW: begin
                if (p_vld_reg && out_ok) begin
                    out_load      = 1'b1;
                    m_tuser_next  = 1'b1;
                    m_tdata_next  = {PP_M_PAD_W'(0), data_rd_reg, PP_SLOT_W'(p_idx_reg)};
                    m_tlast_next  = emit_last;
                    emit_cnt_next = emit_cnt_reg + 1'b1;
                end
                // A waiting word holds the read data; the scan advances only behind it.
                if (!(p_vld_reg && !out_ok)) begin
                    if (scan_cnt_reg != '0 && !(p_vld_reg && emit_last)) begin
                        data_re       = cur_active;
                        p_vld_next    = cur_active;
                        p_idx_next    = scan_idx_reg;
                        scan_idx_next = idx_inc;
                        scan_cnt_next = scan_cnt_reg - 1'b1;
                    end else begin
                        p_vld_next = 1'b0;
                    end
                end
            end
            ST_ACK: begin
                out_load = out_ok;
            end
            default: begin
                p_vld_next = 1'b0;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            decay_rate_reg   <= PP_DECAY_RESET;
            scan_idx_reg     <= '0;
            scan_cnt_reg     <= '0;
            p_vld_reg        <= 1'b0;
            p_idx_reg        <= '0;
            emit_cnt_reg     <= '0;
            act_cnt_reg      <= '0;
            active_reg       <= '0;
            search_start_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            if (cfg_we) begin
                decay_rate_reg <= cfg_wdata;
            end
            scan_idx_reg     <= scan_idx_next;
            scan_cnt_reg     <= scan_cnt_next;
            p_vld_reg        <= p_vld_next;
            p_idx_reg        <= p_idx_next;
            emit_cnt_reg     <= emit_cnt_next;
            act_cnt_reg      <= act_cnt_next;
            active_reg       <= active_next;
            search_start_reg <= search_start_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        dec_reg  <= dec_next;
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

    // Life memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (life_we) begin
            life_mem[life_wa] <= life_wd;
        end
        if (life_re) begin
            life_rd_reg <= life_mem[scan_idx_reg];
        end
    end

    // Payload memory: position, size and colour of each slot.
    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[data_wa] <= item_reg;
        end
        if (data_re) begin
            data_rd_reg <= data_mem[scan_idx_reg];
        end
    end

endmodule

@@ rtl/pp_checker.sv @@
// Port-level checker for particle_pool_next_fit, attached by the bind below.
// Depends on pp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pp_checker
    import pp_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic [PP_M_TDATA_W-1:0] m_tdata,
    input logic                    m_tuser,
    input logic                    m_tlast,
    input logic                    m_tvalid,
    input logic                    m_tready
);

    // An accepted command keeps the block busy for at least the following cycle.
    `PP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
        s_tvalid && s_tready, !s_tready, "input accepted on consecutive cycles")

    // An empty acknowledgement always closes its command.
    `PP_ASSERT(a_ack_is_last, aclk, aresetn,
        !(m_tvalid && !m_tuser) || m_tlast, "empty word without last")

    // An empty acknowledgement carries all-zero data.
    `PP_ASSERT(a_ack_is_zero, aclk, aresetn,
        !(m_tvalid && !m_tuser) || (m_tdata == '0), "empty word with data")

    // A stalled result word is held unchanged.
    `PP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled word changed")

endmodule

bind particle_pool_next_fit pp_checker u_pp_checker (.*);
